FILE: rtl/q8pi_pkg.sv
package q8pi_pkg;

    // request kinds
    typedef enum logic {
        REQ_UPDATE = 1'b0,
        REQ_CLEAR  = 1'b1
    } t_req_kind;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PROP_GAIN        = 3'd0,
        CFG_INT_GAIN         = 3'd1,
        CFG_INTEGRAL_FLOOR   = 3'd2,
        CFG_INTEGRAL_CEILING = 3'd3,
        CFG_DRIVE_FLOOR      = 3'd4,
        CFG_DRIVE_CEILING    = 3'd5
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic signed [15:0] PROP_GAIN_RST        = 16'sd0;
    localparam logic signed [15:0] INT_GAIN_RST         = 16'sd0;
    localparam logic signed [23:0] INTEGRAL_FLOOR_RST   = 24'sh800000;
    localparam logic signed [23:0] INTEGRAL_CEILING_RST = 24'sh7FFFFF;
    localparam logic signed [15:0] DRIVE_FLOOR_RST      = 16'sd0;
    localparam logic signed [15:0] DRIVE_CEILING_RST    = 16'sh7FFF;

    typedef struct packed {
        t_req_kind          req_type;
        logic signed [15:0] target_speed;
        logic signed [15:0] measured_speed;
        logic signed [15:0] feed_forward;
    } t_req;

    typedef struct packed {
        logic signed [15:0] drive;
        logic signed [23:0] integral_now;
        logic               integration_held;
    } t_res;

    typedef struct packed {
        logic signed [15:0] kp;
        logic signed [15:0] ki;
        logic signed [23:0] ifl;
        logic signed [23:0] ice;
        logic signed [15:0] dfl;
        logic signed [15:0] dce;
    } t_cfg;

    // products stage output
    typedef struct packed {
        t_req_kind          req_type;
        logic signed [15:0] ff;
        logic signed [16:0] err;
        logic signed [32:0] kp_err;
        logic signed [32:0] ki_err;
    } t_prod;

    // divide by 256, truncating toward zero
    function automatic logic signed [33:0] f_div256(input logic signed [41:0] v);
        logic signed [41:0] adj;
        adj = v + (v[41] ? 42'sd255 : 42'sd0);
        return $signed(adj[41:8]);
    endfunction

endpackage

FILE: rtl/q8pi_req_if.sv
interface q8pi_req_if import q8pi_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/q8pi_res_if.sv
interface q8pi_res_if import q8pi_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/q8pi_cfg.sv
module q8pi_cfg import q8pi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_idx)
                CFG_PROP_GAIN:        n_cfg.kp  = $signed(i_wdata[15:0]);
                CFG_INT_GAIN:         n_cfg.ki  = $signed(i_wdata[15:0]);
                CFG_INTEGRAL_FLOOR:   n_cfg.ifl = $signed(i_wdata[23:0]);
                CFG_INTEGRAL_CEILING: n_cfg.ice = $signed(i_wdata[23:0]);
                CFG_DRIVE_FLOOR:      n_cfg.dfl = $signed(i_wdata[15:0]);
                CFG_DRIVE_CEILING:    n_cfg.dce = $signed(i_wdata[15:0]);
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp  <= PROP_GAIN_RST;
            r_cfg.ki  <= INT_GAIN_RST;
            r_cfg.ifl <= INTEGRAL_FLOOR_RST;
            r_cfg.ice <= INTEGRAL_CEILING_RST;
            r_cfg.dfl <= DRIVE_FLOOR_RST;
            r_cfg.dce <= DRIVE_CEILING_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/q8pi_front.sv
module q8pi_front import q8pi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    input  t_req  i_req,
    output logic  o_ready,
    output logic  o_p_valid,
    output t_prod o_p,
    input  logic  i_p_ready
);

    logic               r_in_valid;
    t_req               r_in;
    logic               r_p_valid;
    t_prod              r_p;
    t_prod              n_p;
    logic               move_in;
    logic signed [16:0] err;

    assign move_in = r_in_valid && (!r_p_valid || i_p_ready);
    assign o_ready = !r_in_valid || move_in;

    // error and the two state-independent products
    always_comb begin
        err = 17'(r_in.target_speed) - 17'(r_in.measured_speed);
        n_p.req_type = r_in.req_type;
        n_p.ff       = r_in.feed_forward;
        n_p.err      = err;
        n_p.kp_err   = i_cfg.kp * err;
        n_p.ki_err   = i_cfg.ki * err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_p_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (move_in) begin
                r_p_valid <= 1'b1;
            end else if (i_p_ready) begin
                r_p_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_req;
        end
        if (move_in) begin
            r_p <= n_p;
        end
    end

    assign o_p_valid = r_p_valid;
    assign o_p       = r_p;

endmodule

FILE: rtl/q8pi_update.sv
module q8pi_update import q8pi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_p_valid,
    input  t_prod i_p,
    output logic  o_p_ready,
    output logic  o_res_valid,
    output t_res  o_res,
    input  logic  i_res_ready
);

    logic signed [23:0] r_es;
    logic signed [23:0] n_es;
    logic signed [39:0] r_ki_es;
    logic signed [39:0] n_ki_es;
    logic signed [39:0] r_ki_ifl;
    logic signed [39:0] r_ki_ice;
    logic               r_res_valid;
    t_res               r_res;
    t_res               n_res;

    logic               is_clear;
    logic               take;
    logic signed [24:0] cand_sum;
    logic               below;
    logic               above;
    logic signed [23:0] cand;
    logic signed [40:0] ki_cand;
    logic signed [41:0] sum_new;
    logic signed [41:0] sum_old;
    logic signed [34:0] raw_new;
    logic signed [34:0] raw_old;
    logic signed [34:0] raw_sel;
    logic               held;
    logic signed [15:0] drive;

    assign is_clear  = (i_p.req_type == REQ_CLEAR);
    assign o_p_ready = is_clear || !r_res_valid || i_res_ready;
    assign take      = i_p_valid && o_p_ready;

    always_comb begin
        // candidate integral, floor tested first
        cand_sum = 25'(r_es) + 25'(i_p.err);
        below    = cand_sum < 25'(i_cfg.ifl);
        above    = cand_sum > 25'(i_cfg.ice);
        cand     = below ? i_cfg.ifl : (above ? i_cfg.ice : cand_sum[23:0]);

        // ki * candidate from stored products, no multiply in the loop
        if (below) begin
            ki_cand = 41'(r_ki_ifl);
        end else if (above) begin
            ki_cand = 41'(r_ki_ice);
        end else begin
            ki_cand = 41'(r_ki_es) + 41'(i_p.ki_err);
        end

        sum_new = 42'(i_p.kp_err) + 42'(ki_cand);
        sum_old = 42'(i_p.kp_err) + 42'(r_ki_es);
        raw_new = 35'(i_p.ff) + 35'(f_div256(sum_new));
        raw_old = 35'(i_p.ff) + 35'(f_div256(sum_old));

        held = ((raw_new > 35'(i_cfg.dce)) && (i_p.err > 17'sd0))
            || ((raw_new < 35'(i_cfg.dfl)) && (i_p.err < 17'sd0));
        raw_sel = held ? raw_old : raw_new;

        if (raw_sel < 35'(i_cfg.dfl)) begin
            drive = i_cfg.dfl;
        end else if (raw_sel > 35'(i_cfg.dce)) begin
            drive = i_cfg.dce;
        end else begin
            drive = raw_sel[15:0];
        end

        n_res.drive            = drive;
        n_res.integral_now     = held ? r_es : cand;
        n_res.integration_held = held;

        // idle cycles keep ki * integral in step with the gain register
        n_es    = r_es;
        n_ki_es = i_cfg.ki * r_es;
        if (take) begin
            if (is_clear) begin
                n_es    = '0;
                n_ki_es = '0;
            end else if (!held) begin
                n_es    = cand;
                n_ki_es = ki_cand[39:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_es        <= '0;
            r_ki_es     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_es    <= n_es;
            r_ki_es <= n_ki_es;
            if (take && !is_clear) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ki_ifl <= i_cfg.ki * i_cfg.ifl;
        r_ki_ice <= i_cfg.ki * i_cfg.ice;
        if (take && !is_clear) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

FILE: rtl/q8_pi_controller_antiwindup_core.sv
// Q8 fixed-point PI speed controller with conditional-integration anti-windup.
// Each update request (req_type 0) gives target, measured and feed-forward counts
// and yields one result: the clamped drive, the stored integral after the update
// and a flag set when the integration was held back because the unclamped drive
// sat beyond a limit with the error pushing further out. A clear request
// (req_type 1) zeroes the integral and yields no result. Throughput is one
// request per clock while results are taken; a request passes the input,
// product and result registers in turn. The rate is set by the integral
// update, which needs no multiply because ki times the integral is carried
// alongside it, so the loop holds only adds, compares and muxes. Gains and
// limits must be written through the plain write port while no request is
// in flight; the block does not enforce it. Gain products are registered.
module q8_pi_controller_antiwindup_core import q8pi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    q8pi_req_if.sink              i_req,
    q8pi_res_if.source            o_res
);

    t_cfg  cfg;
    logic  p_valid;
    logic  p_ready;
    t_prod p;

    // gain and limit registers
    q8pi_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    // input register, error and the state-independent products
    q8pi_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (i_req.valid),
        .i_req     (i_req.data),
        .o_ready   (i_req.ready),
        .o_p_valid (p_valid),
        .o_p       (p),
        .i_p_ready (p_ready)
    );

    // integral state, anti-windup decision, drive clamp and result register
    q8pi_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_p_valid   (p_valid),
        .i_p         (p),
        .o_p_ready   (p_ready),
        .o_res_valid (o_res.valid),
        .o_res       (o_res.data),
        .i_res_ready (o_res.ready)
    );

endmodule

FILE: tb/q8_pi_controller_antiwindup_core_tb.sv
`timescale 1ns / 1ps

module q8_pi_controller_antiwindup_core_tb;
    import q8pi_pkg::*;

    // cycles with no request, result or register write before the run is abandoned
    localparam int STALL_LIMIT = 5000;
    // settle time after the last expected result (pipeline depth plus margin)
    localparam int DRAIN_CYCLES = 6;
    // unused register slots, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
    // directed drive window used by the windup checks
    localparam int WINDUP_DRIVE_LIM = 1000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    q8pi_req_if req_if ();
    q8pi_res_if res_if ();

    q8_pi_controller_antiwindup_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // predictor state: register mirror and stored integral
    t_cfg   cfg_mirror;
    longint integral_acc;
    // controller outputs predicted for accepted update requests, oldest first
    t_res   ctrl_out_q[$];

    int mismatch_count = 0;
    int src_idle_pct   = 0;
    int snk_idle_pct   = 0;
    // long receiver hold-off, counted down by the receiver process
    int snk_hold_left  = 0;

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // floor is tested first, so an inverted window yields the floor for low values
    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // (kp*err + ki*integ) / 256, signed division truncates toward zero
    function automatic longint pi_term(longint err, longint integ);
        longint kp;
        longint ki;
        kp = longint'($signed(cfg_mirror.kp));
        ki = longint'($signed(cfg_mirror.ki));
        return (kp * err + ki * integ) / 256;
    endfunction

    // one control update; commits the integral unless anti-windup holds it
    function automatic t_res pi_update(t_req r);
        longint err;
        longint cand;
        longint raw;
        longint ff;
        longint ifl;
        longint ice;
        longint dfl;
        longint dce;
        bit     held;
        t_res   o;
        ifl  = longint'($signed(cfg_mirror.ifl));
        ice  = longint'($signed(cfg_mirror.ice));
        dfl  = longint'($signed(cfg_mirror.dfl));
        dce  = longint'($signed(cfg_mirror.dce));
        ff   = longint'($signed(r.feed_forward));
        err  = longint'($signed(r.target_speed)) - longint'($signed(r.measured_speed));
        cand = clamp_to(integral_acc + err, ifl, ice);
        raw  = ff + pi_term(err, cand);
        // unclamped drive past a limit with the error pushing further out
        held = ((raw > dce) && (err > 0)) || ((raw < dfl) && (err < 0));
        if (held) begin
            raw = ff + pi_term(err, integral_acc);
        end else begin
            integral_acc = cand;
        end
        o.drive            = 16'(clamp_to(raw, dfl, dce));
        o.integral_now     = 24'(integral_acc);
        o.integration_held = held;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // monitor: checks results, mirrors register writes, predicts requests
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res exp_out;
        if (!i_rst_n) begin
            cfg_mirror.kp  = PROP_GAIN_RST;
            cfg_mirror.ki  = INT_GAIN_RST;
            cfg_mirror.ifl = INTEGRAL_FLOOR_RST;
            cfg_mirror.ice = INTEGRAL_CEILING_RST;
            cfg_mirror.dfl = DRIVE_FLOOR_RST;
            cfg_mirror.dce = DRIVE_CEILING_RST;
            integral_acc   = 0;
        end else begin
            // result side first: a result never belongs to a request of this edge
            if (res_if.valid && res_if.ready) begin
                if (ctrl_out_q.size() == 0) begin
                    $error("result with no request pending: drive %0d integral %0d held %0b",
                           res_if.data.drive, res_if.data.integral_now,
                           res_if.data.integration_held);
                    mismatch_count++;
                end else begin
                    exp_out = ctrl_out_q.pop_front();
                    if (res_if.data.drive !== exp_out.drive) begin
                        $error("drive: expected %0d, got %0d",
                               exp_out.drive, res_if.data.drive);
                        mismatch_count++;
                    end
                    if (res_if.data.integral_now !== exp_out.integral_now) begin
                        $error("integral_now: expected %0d, got %0d",
                               exp_out.integral_now, res_if.data.integral_now);
                        mismatch_count++;
                    end
                    if (res_if.data.integration_held !== exp_out.integration_held) begin
                        $error("integration_held: expected %0b, got %0b",
                               exp_out.integration_held, res_if.data.integration_held);
                        mismatch_count++;
                    end
                end
            end
            // register writes keep only the register's own width
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROP_GAIN:        cfg_mirror.kp  = i_cfg_wdata[15:0];
                    CFG_INT_GAIN:         cfg_mirror.ki  = i_cfg_wdata[15:0];
                    CFG_INTEGRAL_FLOOR:   cfg_mirror.ifl = i_cfg_wdata[23:0];
                    CFG_INTEGRAL_CEILING: cfg_mirror.ice = i_cfg_wdata[23:0];
                    CFG_DRIVE_FLOOR:      cfg_mirror.dfl = i_cfg_wdata[15:0];
                    CFG_DRIVE_CEILING:    cfg_mirror.dce = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (req_if.valid && req_if.ready) begin
                if (req_if.data.req_type == REQ_CLEAR) begin
                    integral_acc = 0;
                end else begin
                    ctrl_out_q.push_back(pi_update(req_if.data));
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off while snk_hold_left runs down
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (snk_hold_left > 0) begin
                res_if.ready <= 1'b0;
                snk_hold_left--;
            end else begin
                res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // watchdog on cycles without any progress on either port
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || i_cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("q8_pi_controller_antiwindup_core_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // drivers (all called and returning at a falling edge)
    // ------------------------------------------------------------------

    // offer one request, with random sender gaps, and wait for it to be taken
    task automatic send_req(t_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_update(int tgt, int meas, int ff);
        t_req r;
        r.req_type       = REQ_UPDATE;
        r.target_speed   = 16'(tgt);
        r.measured_speed = 16'(meas);
        r.feed_forward   = 16'(ff);
        send_req(r);
    endtask

    // clear request; the other fields carry noise that must be ignored
    task automatic send_clear();
        t_req r;
        r.req_type       = REQ_CLEAR;
        r.target_speed   = 16'($urandom);
        r.measured_speed = 16'($urandom);
        r.feed_forward   = 16'($urandom);
        send_req(r);
    endtask

    // let every pending result and any trailing clear leave the pipeline
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (ctrl_out_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // write enable is held across back-to-back writes and lowered by apply_cfg
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= d;
        @(negedge i_clk);
    endtask

    // write all six registers, upper data bits of the 16-bit ones random to check width masking
    task automatic apply_cfg(t_cfg c);
        cfg_write(CFG_PROP_GAIN,        {8'($urandom), c.kp});
        cfg_write(CFG_INT_GAIN,         {8'($urandom), c.ki});
        cfg_write(CFG_INTEGRAL_FLOOR,   c.ifl);
        cfg_write(CFG_INTEGRAL_CEILING, c.ice);
        cfg_write(CFG_DRIVE_FLOOR,      {8'($urandom), c.dfl});
        cfg_write(CFG_DRIVE_CEILING,    {8'($urandom), c.dce});
        // out-of-range indexes must leave every register alone
        cfg_write(CFG_IDX_SPARE_LO,     24'($urandom));
        cfg_write(CFG_IDX_SPARE_HI,     24'($urandom));
        i_cfg_we <= 1'b0;
        // wait for the registered gain products to settle
        repeat (3) @(negedge i_clk);
    endtask

    function automatic t_cfg make_cfg(int kp, int ki, int ifl, int ice, int dfl, int dce);
        t_cfg c;
        c.kp  = 16'(kp);
        c.ki  = 16'(ki);
        c.ifl = 24'(ifl);
        c.ice = 24'(ice);
        c.dfl = 16'(dfl);
        c.dce = 16'(dce);
        return c;
    endfunction

    // mostly moderate settings, with occasional extremes and inverted windows
    function automatic t_cfg random_cfg();
        t_cfg c;
        case ($urandom_range(7))
            0:       c.kp = 16'sh8000;
            1:       c.kp = 16'sh7FFF;
            default: c.kp = 16'(int'($urandom_range(2047)) - 1024);
        endcase
        case ($urandom_range(7))
            0:       c.ki = 16'sh8000;
            1:       c.ki = 16'sh7FFF;
            default: c.ki = 16'(int'($urandom_range(255)) - 64);
        endcase
        case ($urandom_range(7))
            0:       c.ifl = 24'sh800000;
            1:       c.ifl = 24'sh7FFFFF;
            default: c.ifl = 24'(-int'($urandom_range(200000)));
        endcase
        case ($urandom_range(7))
            0:       c.ice = 24'sh7FFFFF;
            1:       c.ice = 24'sh800000;
            default: c.ice = 24'(int'($urandom_range(200000)));
        endcase
        case ($urandom_range(7))
            0:       c.dfl = 16'sh8000;
            1:       c.dfl = 16'sh7FFF;
            default: c.dfl = 16'(-int'($urandom_range(20000)));
        endcase
        case ($urandom_range(7))
            0:       c.dce = 16'sh7FFF;
            1:       c.dce = 16'sh8000;
            default: c.dce = 16'(int'($urandom_range(20000)));
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset gains are zero: drive is feed-forward clamped to [0, 32767]
    task automatic test_reset_defaults();
        send_update(100, 40, 32767);
        send_update(-32768, 32767, -32768);   // negative error below floor, held
        send_update(0, 0, 0);
        send_update(5, 6, 1234);
        wait_idle();
    endtask

    // full-scale speeds and feed-forward, plus a clear with noise in its fields
    task automatic test_field_extremes();
        apply_cfg(make_cfg(256, 16, -8388608, 8388607, -32768, 32767));
        send_update(32767, -32768, 0);
        send_update(-32768, 32767, 0);
        send_update(0, 0, 32767);
        send_update(0, 0, -32768);
        send_clear();
        send_update(1, 0, 0);
        wait_idle();
    endtask

    // drive saturation with the error pushing outward holds the integral
    task automatic test_windup_hold();
        apply_cfg(make_cfg(256, 256, -50000, 50000,
                           -WINDUP_DRIVE_LIM, WINDUP_DRIVE_LIM));
        send_update(800, 0, 0);
        send_update(800, 0, 0);     // past the ceiling, positive error
        send_update(0, 600, 0);     // negative error, past the floor
        send_update(-2000, 0, 0);   // past the floor, negative error
        send_update(-2000, 0, 0);
        send_clear();
        send_update(10, 0, 0);
        wait_idle();
    endtask

    // integral pinned at its own limits
    task automatic test_integral_clamp();
        apply_cfg(make_cfg(0, 64, -100, 100, -32768, 32767));
        send_update(70, 0, 0);
        send_update(70, 0, 0);
        send_update(-90, 0, 0);
        send_update(-90, 0, 0);
        send_update(-90, 0, 0);
        wait_idle();
    endtask

    // floor above ceiling on both windows; then opposite-sign extreme gains
    task automatic test_inverted_and_gain_extremes();
        apply_cfg(make_cfg(256, 256, 100, -100, 500, -500));
        send_update(-300, 0, 0);
        send_update(0, 0, 0);
        send_update(300, 0, 0);
        wait_idle();
        apply_cfg(make_cfg(-32768, 32767, -8388608, 8388607, -32768, 32767));
        send_update(32767, -32768, 100);
        wait_idle();
        apply_cfg(make_cfg(32767, -32768, 8388607, 8388607, 32767, 32767));
        send_update(-32768, 32767, -100);
        wait_idle();
    endtask

    // random traffic in blocks, each block under a fresh register setting
    task automatic test_random_traffic(int src_pct, int snk_pct, int n_items);
        int tgt;
        int delta;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % 60 == 0) begin
                wait_idle();
                apply_cfg(random_cfg());
            end
            if ($urandom_range(99) < 8) begin
                send_clear();
            end else begin
                tgt = int'($urandom_range(65535)) - 32768;
                // half the updates track the target closely to stay out of saturation
                delta = ($urandom_range(1)) ? int'($urandom_range(600)) - 300
                                            : int'($urandom_range(65535)) - 32768;
                send_update(tgt, tgt + delta,
                            ($urandom_range(1)) ? int'($urandom_range(65535)) - 32768
                                                : int'($urandom_range(4000)) - 2000);
            end
        end
        wait_idle();
    endtask

    // receiver holds off long enough for the pipeline to fill and stall requests
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        apply_cfg(make_cfg(128, 8, -100000, 100000, -20000, 20000));
        snk_hold_left = 400;
        for (int i = 0; i < 60; i++) begin
            send_update(int'($urandom_range(2000)) - 1000, int'($urandom_range(2000)) - 1000,
                        int'($urandom_range(65535)) - 32768);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct = 34;
        snk_idle_pct = 59;
        test_reset_defaults();
        test_field_extremes();
        test_windup_hold();
        test_integral_clamp();
        test_inverted_and_gain_extremes();

        test_random_traffic(34, 59, 360);
        test_random_traffic(59, 34, 360);
        test_random_traffic(0, 0, 360);
        test_backpressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("q8_pi_controller_antiwindup_core_tb: clean");
        else
            $display("q8_pi_controller_antiwindup_core_tb: errors");
        $finish;
    end

endmodule
